// ===== design/amd_pkg.sv =====
// amd_pkg: constants, types and the row dilation function of the alpha mask dilation unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package amd_pkg;

  // image geometry and dilation radius
  localparam int IMAGE_WIDTH   = 192;
  localparam int IMAGE_HEIGHT  = 288;
  localparam int DILATE_RADIUS = 4;

  // output word geometry
  localparam int WORD_BITS = 64;
  localparam int WORDS     = (IMAGE_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_BITS  = WORDS * WORD_BITS;
  localparam int WIN_ROWS  = 2 * DILATE_RADIUS + 1;

  // field and counter widths
  localparam int ALPHA_W      = 8;
  localparam int MASK_ROW_W   = 9;
  localparam int WORD_INDEX_W = 2;
  localparam int COL_W        = $clog2(IMAGE_WIDTH);
  localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
  localparam int SLOT_W       = $clog2(WIN_ROWS);
  localparam int WIDX_W       = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // one completed, horizontally dilated row handed from front to back
  typedef struct packed {
    row_t              bits;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } row_job_t;

  // horizontal dilation with no wrap, columns past the image width forced to zero
  function automatic row_t dilate_row(input row_t src);
    row_t acc;
    row_t valid_cols;
    acc = src;
    valid_cols = '0;
    for (int n = 1; n <= DILATE_RADIUS; n++) begin
      acc = acc | (src << n) | (src >> n);
    end
    for (int i = 0; i < ROW_BITS; i++) begin
      valid_cols[i] = (i < IMAGE_WIDTH);
    end
    return acc & valid_cols;
  endfunction

endpackage

`default_nettype wire

// ===== design/amd_job_fifo.sv =====
// amd_job_fifo: two-entry queue of completed row jobs between front and back
// depends on amd_pkg for row_job_t
`timescale 1ns / 1ps
`default_nettype none

module amd_job_fifo
  import amd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire row_job_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  wire logic     pop_i,
  output row_job_t      pop_data_o
);

  localparam int DEPTH = 2;

  row_job_t   mem_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'(DEPTH));
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(DEPTH))
    else $error("job queue count over depth");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("row job pushed into full queue");

endmodule

`default_nettype wire

// ===== design/amd_front.sv =====
// amd_front: accepts alpha items, assembles a row and dilates it horizontally
// depends on amd_pkg; pushes row jobs into amd_job_fifo
`timescale 1ns / 1ps
`default_nettype none

module amd_front
  import amd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ALPHA_W-1:0] alpha_i,
  input  wire logic               frame_start_i,
  output logic                    job_push_o,
  output row_job_t                job_o,
  input  wire logic               job_full_i
);

  logic [COL_W-1:0]  col_q, col_d, col_cur;
  logic [ROW_W-1:0]  row_q, row_d, row_cur;
  logic [SLOT_W-1:0] slot_q, slot_d, slot_cur;
  row_t              asm_q, asm_d, asm_cur, asm_set;
  logic              accept, row_end, row_last;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // frame start restarts the counters before this item is placed
  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    row_cur  = frame_start_i ? '0 : row_q;
    slot_cur = frame_start_i ? '0 : slot_q;
    asm_cur  = frame_start_i ? '0 : asm_q;
    asm_set  = asm_cur | (row_t'(alpha_i != '0) << col_cur);
    row_end  = (col_cur == COL_W'(IMAGE_WIDTH - 1));
    row_last = (row_cur == ROW_W'(IMAGE_HEIGHT - 1));
  end

  // completed row job
  always_comb begin
    job_push_o = accept && row_end;
    job_o.bits = dilate_row(asm_set);
    job_o.row  = row_cur;
    job_o.slot = slot_cur;
    job_o.last = row_last;
  end

  // column, row and window slot counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    asm_d  = asm_q;
    if (accept) begin
      if (row_end) begin
        col_d  = '0;
        asm_d  = '0;
        row_d  = row_last ? '0 : row_cur + ROW_W'(1);
        slot_d = (slot_cur == SLOT_W'(WIN_ROWS - 1)) ? '0 : slot_cur + SLOT_W'(1);
      end else begin
        col_d  = col_cur + COL_W'(1);
        asm_d  = asm_set;
        row_d  = row_cur;
        slot_d = slot_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      asm_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      asm_q  <= asm_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/amd_back.sv =====
// amd_back: holds the window of dilated rows and emits vertically dilated mask words
// depends on amd_pkg; pops row jobs from amd_job_fifo
`timescale 1ns / 1ps
`default_nettype none

module amd_back
  import amd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     job_valid_i,
  input  wire row_job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [MASK_ROW_W-1:0]         mask_row_o,
  output logic [WORD_INDEX_W-1:0]       word_index_o,
  output logic [WORD_BITS-1:0]          mask_bits_o,
  output logic                          frame_last_o
);

  // window of dilated rows, slot = arrival row mod window size
  row_t ring_q [WIN_ROWS];

  logic              busy_q, busy_d;
  logic [ROW_W-1:0]  r_q, py_q, py_d, end_q;
  logic [ROW_W-1:0]  first_py, end_py;
  logic [SLOT_W-1:0] slot_q;
  logic              last_q;
  logic [WIDX_W-1:0] w_q, w_d;
  logic              start_emit, load, word_last;

  logic                    out_valid_q;
  logic [MASK_ROW_W-1:0]   mask_row_q;
  logic [WORD_INDEX_W-1:0] word_index_q;
  word_t                   mask_bits_q;
  logic                    frame_last_q;

  logic [ROW_W:0] y0, y1, lo, hi, py_ext, r_ext;
  logic [SLOT_W:0] age [WIN_ROWS];
  word_t acc;

  assign job_pop_o = job_valid_i && !busy_q;
  assign load      = busy_q && (!out_valid_q || !out_stall_i);
  assign word_last = (w_q == WIDX_W'(WORDS - 1));

  // output rows that a completed row releases
  always_comb begin
    if (job_i.last) begin
      first_py   = (job_i.row >= ROW_W'(DILATE_RADIUS))
                   ? job_i.row - ROW_W'(DILATE_RADIUS) : '0;
      end_py     = ROW_W'(IMAGE_HEIGHT - 1);
      start_emit = 1'b1;
    end else begin
      first_py   = job_i.row - ROW_W'(DILATE_RADIUS);
      end_py     = first_py;
      start_emit = (job_i.row >= ROW_W'(DILATE_RADIUS));
    end
  end

  // OR of the window rows within the radius of the current output row
  always_comb begin
    py_ext = {1'b0, py_q};
    r_ext  = {1'b0, r_q};
    y0 = (py_q >= ROW_W'(DILATE_RADIUS)) ? py_ext - (ROW_W+1)'(DILATE_RADIUS) : '0;
    y1 = (py_ext + (ROW_W+1)'(DILATE_RADIUS) > (ROW_W+1)'(IMAGE_HEIGHT - 1))
         ? (ROW_W+1)'(IMAGE_HEIGHT - 1) : py_ext + (ROW_W+1)'(DILATE_RADIUS);
    lo  = r_ext - y1;
    hi  = r_ext - y0;
    acc = '0;
    for (int s = 0; s < WIN_ROWS; s++) begin
      age[s] = (slot_q >= SLOT_W'(s))
               ? {1'b0, slot_q} - (SLOT_W+1)'(s)
               : {1'b0, slot_q} + (SLOT_W+1)'(WIN_ROWS - s);
      if ((ROW_W+1)'(age[s]) >= lo && (ROW_W+1)'(age[s]) <= hi) begin
        acc = acc | ring_q[s][w_q*WORD_BITS +: WORD_BITS];
      end
    end
  end

  // word and row sequencing
  always_comb begin
    busy_d = busy_q;
    py_d   = py_q;
    w_d    = w_q;
    if (job_pop_o) begin
      busy_d = start_emit;
      py_d   = first_py;
      w_d    = '0;
    end else if (load) begin
      if (word_last) begin
        w_d = '0;
        if (py_q == end_q) begin
          busy_d = 1'b0;
        end else begin
          py_d = py_q + ROW_W'(1);
        end
      end else begin
        w_d = w_q + WIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      py_q        <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      py_q   <= py_d;
      w_q    <= w_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // job fields and window write
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ring_q[job_i.slot] <= job_i.bits;
      r_q                <= job_i.row;
      slot_q             <= job_i.slot;
      last_q             <= job_i.last;
      end_q              <= end_py;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_row_q   <= MASK_ROW_W'(ROW_W'(IMAGE_HEIGHT - 1) - py_q);
      word_index_q <= WORD_INDEX_W'(w_q);
      mask_bits_q  <= acc;
      frame_last_q <= last_q && (py_q == end_q) && word_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mask_row_o   = mask_row_q;
  assign word_index_o = word_index_q;
  assign mask_bits_o  = mask_bits_q;
  assign frame_last_o = frame_last_q;

  // the output row never runs past the end of its range
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> py_q <= end_q)
    else $error("output row past end of range");

  // an ordinary row releases exactly one output row
  assert property (@(posedge clk_i) disable iff (!rst_ni) (load && !last_q) |-> py_q == end_q)
    else $error("ordinary row emitting more than one output row");

  // frame end flag only on the final word of a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> word_index_o == WORD_INDEX_W'(WORDS - 1))
    else $error("frame end flag on a word that is not the last of its row");

endmodule

`default_nettype wire

// ===== design/alpha_mask_dilate_unit.sv =====
// alpha_mask_dilate_unit: top level of the streaming square dilation of an alpha mask
// depends on amd_pkg, amd_front, amd_job_fifo and amd_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one alpha item per clock when not stalled, in raster order, bottom row first,
// and returns the mask dilated by DILATE_RADIUS in both directions as 64-bit words,
// three per row at the default width. The front accepts one pixel every unstalled
// cycle and, on the last pixel of a row, dilates the row horizontally and queues it
// (two rows of queue). The back writes a queued row into its nine-row window and then
// sends one word per unstalled output cycle through an output register: WORDS words
// for each row from the fifth on, and 5*WORDS words after the last row of the frame,
// which flushes the bottom rows. Input is stalled only when both queue entries are
// held, i.e. when the output stalls while two more rows arrive and the back holds one.

module alpha_mask_dilate_unit
  import amd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [ALPHA_W-1:0]       alpha_i,
  input  wire logic                     frame_start_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [MASK_ROW_W-1:0]         mask_row_o,
  output logic [WORD_INDEX_W-1:0]       word_index_o,
  output logic [WORD_BITS-1:0]          mask_bits_o,
  output logic                          frame_last_o
);

  logic     job_push, job_full, job_valid, job_pop;
  row_job_t push_job, pop_job;

  // row assembly and horizontal dilation
  amd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alpha_i       (alpha_i),
    .frame_start_i (frame_start_i),
    .job_push_o    (job_push),
    .job_o         (push_job),
    .job_full_i    (job_full)
  );

  // queue of completed rows
  amd_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .full_o      (job_full),
    .valid_o     (job_valid),
    .pop_i       (job_pop),
    .pop_data_o  (pop_job)
  );

  // vertical dilation and word output
  amd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (pop_job),
    .job_pop_o    (job_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mask_row_o   (mask_row_o),
    .word_index_o (word_index_o),
    .mask_bits_o  (mask_bits_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for alpha_mask_dilate_unit, streams alpha items and checks mask words
// depends on amd_pkg and the design files of alpha_mask_dilate_unit
`timescale 1ns / 1ps

module tb;
  import amd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [WORDS*WORD_BITS-1:0] line_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               start;
  } pixel_t;

  typedef struct packed {
    logic [MASK_ROW_W-1:0]   mask_row;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [WORD_BITS-1:0]    bits;
    logic                    last;
  } mask_word_t;

  typedef enum logic [2:0] {
    FILL_EMPTY, FILL_SPARSE, FILL_HALF, FILL_DENSE, FILL_FULL
  } fill_e;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_COIN, STALL_RARE, STALL_BEAT
  } stall_e;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [ALPHA_W-1:0]      alpha_i       = '0;
  logic                    frame_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic [MASK_ROW_W-1:0]   mask_row_o;
  logic [WORD_INDEX_W-1:0] word_index_o;
  logic [WORD_BITS-1:0]    mask_bits_o;
  logic                    frame_last_o;

  // items waiting to be sent and mask words still due
  pixel_t     alpha_backlog[$];
  mask_word_t mask_due[$];

  // predictor state
  line_t       arriving_line;
  line_t       spread_ring [WIN_ROWS];
  int          col_next;
  int          row_next;

  // handshake bookkeeping and stimulus control
  bit          pixel_taken   = 1'b0;
  bit          sender_steady = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  stall_e      stall_mode    = STALL_NONE;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  alpha_mask_dilate_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alpha_i       (alpha_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mask_row_o    (mask_row_o),
    .word_index_o  (word_index_o),
    .mask_bits_o   (mask_bits_o),
    .frame_last_o  (frame_last_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // horizontal growth of a row by the radius, clipped at both row edges
  function automatic line_t spread_across(input line_t src);
    line_t grown;
    grown = '0;
    for (int c = 0; c < IMAGE_WIDTH; c++) begin
      for (int d = -DILATE_RADIUS; d <= DILATE_RADIUS; d++) begin
        if (c + d >= 0 && c + d < IMAGE_WIDTH && src[c + d]) grown[c] = 1'b1;
      end
    end
    return grown;
  endfunction

  // take one pixel; on a completed row, queue every mask word that becomes final
  function automatic void absorb_pixel(input logic [ALPHA_W-1:0] alpha, input logic start);
    int         arr;
    int         lo;
    int         hi;
    int         y0;
    int         y1;
    line_t      merged;
    mask_word_t word;
    if (start) begin
      col_next      = 0;
      row_next      = 0;
      arriving_line = '0;
    end
    if (alpha != '0) arriving_line[col_next] = 1'b1;
    col_next++;
    if (col_next < IMAGE_WIDTH) return;
    arr = row_next;
    spread_ring[arr % WIN_ROWS] = spread_across(arriving_line);
    arriving_line = '0;
    col_next      = 0;
    // one row normally; the last arriving row flushes the bottom rows of the window
    lo = arr - DILATE_RADIUS;
    hi = lo;
    if (arr == IMAGE_HEIGHT - 1) begin
      if (lo < 0) lo = 0;
      hi = IMAGE_HEIGHT - 1;
    end
    for (int py = lo; py <= hi; py++) begin
      if (py >= 0) begin
        y0 = (py - DILATE_RADIUS < 0) ? 0 : py - DILATE_RADIUS;
        y1 = (py + DILATE_RADIUS > IMAGE_HEIGHT - 1) ? IMAGE_HEIGHT - 1 : py + DILATE_RADIUS;
        merged = '0;
        for (int y = y0; y <= y1; y++) merged |= spread_ring[y % WIN_ROWS];
        for (int w = 0; w < WORDS; w++) begin
          word.mask_row   = MASK_ROW_W'(IMAGE_HEIGHT - 1 - py);
          word.word_index = WORD_INDEX_W'(w);
          word.bits       = merged[w*WORD_BITS +: WORD_BITS];
          word.last       = (arr == IMAGE_HEIGHT - 1) && (py == hi) && (w == WORDS - 1);
          mask_due.push_back(word);
        end
      end
    end
    row_next = (arr + 1 >= IMAGE_HEIGHT) ? 0 : arr + 1;
  endfunction

  // row fill weighted toward empty and sparse rows
  function automatic fill_e pick_fill();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return FILL_EMPTY;
    if (roll < 60) return FILL_SPARSE;
    if (roll < 78) return FILL_HALF;
    if (roll < 93) return FILL_DENSE;
    return FILL_FULL;
  endfunction

  // queue a run of pixels at the given fill, frame start on the first one if asked
  task automatic queue_run(input int unsigned count, input fill_e fill, input bit start);
    pixel_t      pix;
    int unsigned on_odds;
    case (fill)
      FILL_EMPTY:  on_odds = 0;
      FILL_SPARSE: on_odds = 2;
      FILL_HALF:   on_odds = 32;
      FILL_DENSE:  on_odds = 56;
      default:     on_odds = 64;
    endcase
    for (int unsigned k = 0; k < count; k++) begin
      pix.start = start && (k == 0);
      pix.alpha = ($urandom_range(0, 63) < on_odds) ? 8'($urandom_range(1, 255)) : '0;
      alpha_backlog.push_back(pix);
    end
  endtask

  // wait until every queued item is taken and every mask word is back
  task automatic wait_idle();
    while (alpha_backlog.size() != 0 || in_valid_i || mask_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // sender: bursts of items with random idle gaps between them
  always @(negedge clk_i) begin : sender
    logic   offer;
    pixel_t pix;
    offer     = 1'b0;
    pix.alpha = alpha_i;
    pix.start = frame_start_i;
    if (!rst_ni) begin
      offer = 1'b0;
    end else if (in_valid_i && !pixel_taken) begin
      offer = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (alpha_backlog.size() != 0) begin
      pix   = alpha_backlog.pop_front();
      offer = 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                                 : $urandom_range(1, 48);
        gap_left   = (sender_steady || $urandom_range(0, 1) == 0) ? 0
                                                                  : $urandom_range(1, 6);
      end
    end
    in_valid_i    <= offer;
    alpha_i       <= pix.alpha;
    frame_start_i <= pix.start;
  end

  // receiver: stall pattern changes mode now and then, plus long hold-offs on request
  always @(negedge clk_i) begin : receiver
    logic stall_next;
    stall_next = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (holds_served < holds_asked && out_valid_o) begin
        holds_served++;
        hold_left  = HOLD_CYCLES;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(64, 512);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE: stall_next = 1'b0;
          STALL_COIN: stall_next = ($urandom_range(0, 1) == 1);
          STALL_RARE: stall_next = ($urandom_range(0, 7) == 0);
          STALL_BEAT: stall_next = (mode_left % 3 == 0);
        endcase
      end
    end
    out_stall_i <= stall_next;
  end

  // monitor: predict on each accepted item, then check each accepted mask word
  always @(posedge clk_i) begin : monitor
    mask_word_t got;
    mask_word_t want;
    pixel_taken = rst_ni && in_valid_i && !in_stall_o;
    if (pixel_taken) absorb_pixel(alpha_i, frame_start_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.mask_row   = mask_row_o;
      got.word_index = word_index_o;
      got.bits       = mask_bits_o;
      got.last       = frame_last_o;
      if (mask_due.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected mask word: row %0d word %0d bits %h last %b",
                   got.mask_row, got.word_index, got.bits, got.last);
        end
        fail_count++;
      end else begin
        want = mask_due.pop_front();
        if (got.mask_row !== want.mask_row || got.word_index !== want.word_index ||
            got.bits !== want.bits || got.last !== want.last) begin
          if (fail_count < MAX_REPORTS) begin
            $display("mask word mismatch: expected row %0d word %0d bits %h last %b",
                     want.mask_row, want.word_index, want.bits, want.last);
            $display("                    got      row %0d word %0d bits %h last %b",
                     got.mask_row, got.word_index, got.bits, got.last);
          end
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // stimulus phases and final verdict
  initial begin : stimulus
    pixel_t      pix;
    int unsigned rows;
    col_next      = 0;
    row_next      = 0;
    arriving_line = '0;
    foreach (spread_ring[i]) spread_ring[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no frame start after reset: word edges and row edges first
    for (int c = 0; c < IMAGE_WIDTH; c++) begin
      pix.start = 1'b0;
      case (c)
        0:               pix.alpha = 8'h01;
        63:              pix.alpha = 8'hFF;
        64:              pix.alpha = 8'h80;
        127:             pix.alpha = 8'h7F;
        128:             pix.alpha = 8'h01;
        IMAGE_WIDTH - 1: pix.alpha = 8'hFF;
        default:         pix.alpha = 8'h00;
      endcase
      alpha_backlog.push_back(pix);
    end
    queue_run(IMAGE_WIDTH, FILL_EMPTY, 1'b0);
    // lone pixel in the middle of a row
    queue_run(100, FILL_EMPTY, 1'b0);
    pix.alpha = 8'h02;
    pix.start = 1'b0;
    alpha_backlog.push_back(pix);
    queue_run(IMAGE_WIDTH - 101, FILL_EMPTY, 1'b0);
    for (int r = 3; r < 12; r++) queue_run(IMAGE_WIDTH, fill_e'(r % 5), 1'b0);
    queue_run(50, FILL_HALF, 1'b0);
    wait_idle();

    // frame start in mid row abandons the partial frame, then again after 90 columns
    queue_run(IMAGE_WIDTH, FILL_SPARSE, 1'b1);
    for (int r = 1; r < 6; r++) queue_run(IMAGE_WIDTH, pick_fill(), 1'b0);
    queue_run(90, FILL_DENSE, 1'b0);
    queue_run(IMAGE_WIDTH, FILL_DENSE, 1'b1);
    for (int r = 1; r < 9; r++) queue_run(IMAGE_WIDTH, pick_fill(), 1'b0);
    wait_idle();

    // one whole frame, ending in the flush of the bottom rows
    queue_run(IMAGE_WIDTH, pick_fill(), 1'b1);
    for (int r = 1; r < IMAGE_HEIGHT; r++) queue_run(IMAGE_WIDTH, pick_fill(), 1'b0);
    wait_idle();

    // next frame with no frame start, receiver holds off while items keep coming
    sender_steady = 1'b1;
    holds_asked++;
    for (int r = 0; r < 14; r++) queue_run(IMAGE_WIDTH, pick_fill(), 1'b0);
    queue_run(70, FILL_HALF, 1'b0);
    wait_idle();
    sender_steady = 1'b0;

    // random frames, some continuing the previous one, some cut short
    for (int f = 0; f < 5; f++) begin
      rows = $urandom_range(5, 12);
      queue_run(IMAGE_WIDTH, pick_fill(), $urandom_range(0, 3) != 0);
      for (int r = 1; r < rows; r++) queue_run(IMAGE_WIDTH, pick_fill(), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        queue_run($urandom_range(1, IMAGE_WIDTH - 1), pick_fill(), 1'b0);
      end
      if ($urandom_range(0, 2) == 0) begin
        queue_run($urandom_range(1, 40), FILL_HALF, 1'b1);
      end
    end
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mask_due.size() != 0) begin
      $display("%0d mask words never arrived", mask_due.size());
      fail_count += mask_due.size();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
